@@ sv/assert_macros.svh @@
// Concurrent check helpers; each expects clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Hold expr at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Require cons whenever ante is seen.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ sv/ptts_pkg.sv @@
`default_nettype none
package ptts_pkg;

	localparam int NUM_SLOTS_DEF = 8;
	localparam int MAX_SLOTS     = 64;

	localparam logic [2:0] CMD_TICK    = 3'd0;
	localparam logic [2:0] CMD_CREATE  = 3'd1;
	localparam logic [2:0] CMD_DELETE  = 3'd2;
	localparam logic [2:0] CMD_SUSPEND = 3'd3;
	localparam logic [2:0] CMD_RESUME  = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_TAKEN = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_FIRED  = 2'd1;
	localparam logic [1:0] KIND_EMPTY  = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [5:0] slot;
		logic [1:0] status;
		logic       last;
	} res_t;

	typedef struct packed {
		logic res_v;
		logic create_wr;
		res_t res;
	} cmd_out_t;

endpackage
`default_nettype wire

@@ sv/ptts_ram.sv @@
`default_nettype none
module ptts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

@@ sv/ptts_cmd.sv @@
`default_nettype none
module ptts_cmd #(
	parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF,
	parameter int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              acc,
	input  wire logic [2:0]        command,
	input  wire logic [7:0]        slot,
	input  wire logic [IDX_W-1:0]  scan_idx,
	output logic                   scan_act,
	output ptts_pkg::cmd_out_t     cmd_out
);
	import ptts_pkg::*;

	logic [NUM_SLOTS-1:0] occ_q;
	logic [NUM_SLOTS-1:0] run_q;
	logic                 in_range;
	logic [IDX_W-1:0]     sidx;
	logic                 occ_s;
	logic                 known;
	logic [1:0]           st;

	assign in_range = {1'b0, slot} < 9'(NUM_SLOTS);
	assign sidx     = slot[IDX_W-1:0];
	assign occ_s    = in_range & occ_q[sidx];
	assign known    = (command == CMD_CREATE) || (command == CMD_DELETE) ||
		(command == CMD_SUSPEND) || (command == CMD_RESUME);
	assign scan_act = occ_q[scan_idx] & run_q[scan_idx];

	always_comb begin
		priority if (!in_range) begin
			st = ST_RANGE;
		end else if (command == CMD_CREATE) begin
			st = occ_s ? ST_TAKEN : ST_OK;
		end else if (!occ_s) begin
			st = ST_EMPTY;
		end else begin
			st = ST_OK;
		end
	end

	always_comb begin
		cmd_out.res_v      = acc & known;
		cmd_out.create_wr  = acc & (command == CMD_CREATE) & in_range & !occ_s;
		cmd_out.res.kind   = KIND_STATUS;
		cmd_out.res.slot   = slot[5:0];
		cmd_out.res.status = st;
		cmd_out.res.last   = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
			run_q <= '0;
		end else if (acc && in_range) begin
			unique case (command)
				CMD_CREATE: begin
					if (!occ_s) begin
						occ_q[sidx] <= 1'b1;
						run_q[sidx] <= 1'b1;
					end
				end
				CMD_DELETE: begin
					if (occ_s) begin
						occ_q[sidx] <= 1'b0;
						run_q[sidx] <= 1'b0;
					end
				end
				CMD_SUSPEND: begin
					if (occ_s) begin
						run_q[sidx] <= 1'b0;
					end
				end
				CMD_RESUME: begin
					if (occ_s) begin
						run_q[sidx] <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

@@ sv/periodic_task_tick_scheduler_top.sv @@
// channel  signals                                   handshake
// in       command, slot, period, first_delay        in_valid / in_stall
// out      result_kind, fired_slot, status, last     out_valid / out_stall
//
// Create, delete, suspend, resume: the status beat lands in the output register.
// Tick: one slot per cycle through a 1R1W slot RAM, unless out_stall holds the scan.
// A fired beat waits in a pending register until the next fire or the end of the scan marks it.
// out_stall holds the scan only when a pending beat must leave and the output register is full.
// Reset clears the slot flags and control; the RAM needs no clearing pass.
`default_nettype none
module periodic_task_tick_scheduler_top #(
	parameter int NUM_SLOTS = ptts_pkg::NUM_SLOTS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [2:0] command,
	input  wire logic [7:0] slot,
	input  wire logic [7:0] period,
	input  wire logic [7:0] first_delay,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      result_kind,
	output logic [5:0]      fired_slot,
	output logic [1:0]      status,
	output logic            last
);
	import ptts_pkg::*;

	localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W = $clog2(NUM_SLOTS + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(NUM_SLOTS);

	logic             busy_q;
	logic [CNT_W-1:0] scan_q;
	logic             v_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             pend_v_q;
	logic [IDX_W-1:0] pend_idx_q;
	logic             out_v_q;
	res_t             out_res_q;

	logic             out_free;
	logic             in_acc;
	logic             is_tick;
	logic             cmd_acc;
	cmd_out_t         cmd_out;
	logic             act;
	logic [15:0]      rdata;
	logic [7:0]       cd;
	logic [7:0]       per;
	logic             fire;
	logic             hold_s1;
	logic             issue;
	logic             tick_wr;
	logic             flush;
	logic             done;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [15:0]      ram_wdata;
	res_t             nxt_res;

	assign out_free = !out_v_q || !out_stall;
	assign in_stall = busy_q || !out_free;
	assign in_acc   = in_valid && !in_stall;
	assign is_tick  = command == CMD_TICK;
	assign cmd_acc  = in_acc && !is_tick;

	ptts_cmd #(
		.NUM_SLOTS(NUM_SLOTS),
		.IDX_W    (IDX_W)
	) u_cmd (
		.clk     (clk),
		.arst_n  (arst_n),
		.acc     (cmd_acc),
		.command (command),
		.slot    (slot),
		.scan_idx(idx_s1),
		.scan_act(act),
		.cmd_out (cmd_out)
	);

	assign cd      = rdata[7:0];
	assign per     = rdata[15:8];
	assign fire    = v_s1 && act && (cd == 8'd0);
	assign hold_s1 = fire && pend_v_q && !out_free;
	assign issue   = busy_q && (scan_q != CNT_END) && !hold_s1;
	assign tick_wr = v_s1 && act && !hold_s1;
	assign flush   = fire && pend_v_q && out_free;
	assign done    = busy_q && (scan_q == CNT_END) && !v_s1 && out_free;

	always_comb begin
		ram_we = tick_wr || cmd_out.create_wr;
		if (cmd_out.create_wr) begin
			ram_waddr = slot[IDX_W-1:0];
			ram_wdata = {period, first_delay};
		end else begin
			ram_waddr = idx_s1;
			ram_wdata = {per, fire ? per : cd - 8'd1};
		end
	end

	ptts_ram #(
		.WIDTH(16),
		.DEPTH(NUM_SLOTS),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (issue),
		.raddr(scan_q[IDX_W-1:0]),
		.rdata(rdata)
	);

	always_comb begin
		nxt_res = cmd_out.res;
		if (flush || done) begin
			nxt_res.kind   = (done && !pend_v_q) ? KIND_EMPTY : KIND_FIRED;
			nxt_res.slot   = (done && !pend_v_q) ? 6'd0 : 6'(pend_idx_q);
			nxt_res.status = ST_OK;
			nxt_res.last   = done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			scan_q   <= '0;
			v_s1     <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (in_acc && is_tick) begin
				busy_q   <= 1'b1;
				scan_q   <= '0;
				pend_v_q <= 1'b0;
			end else if (done) begin
				busy_q <= 1'b0;
			end else begin
				if (issue) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (fire && !hold_s1) begin
					pend_v_q <= 1'b1;
				end
			end
			if (!hold_s1) begin
				v_s1 <= issue;
			end
			if (out_free) begin
				out_v_q <= cmd_out.res_v || flush || done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!hold_s1) begin
			idx_s1 <= scan_q[IDX_W-1:0];
		end
		if (fire && !hold_s1) begin
			pend_idx_q <= idx_s1;
		end
		if (out_free) begin
			out_res_q <= nxt_res;
		end
	end

	assign out_valid   = out_v_q;
	assign result_kind = out_res_q.kind;
	assign fired_slot  = out_res_q.slot;
	assign status      = out_res_q.status;
	assign last        = out_res_q.last;

`include "assert_macros.svh"

	`ASSERT_IMPLIES(a_s1_in_scan, v_s1, busy_q, "slot stage active outside a tick")
	`ASSERT_ALWAYS(a_one_writer, !(tick_wr && cmd_out.create_wr), "slot RAM write conflict")
	`ASSERT_IMPLIES(a_empty_last, out_v_q && (out_res_q.kind == KIND_EMPTY),
		out_res_q.last && (out_res_q.slot == 6'd0), "empty tick beat malformed")
	`ASSERT_IMPLIES(a_fired_ok, out_v_q && (out_res_q.kind == KIND_FIRED),
		out_res_q.status == ST_OK, "fired beat carries a status")

endmodule
`default_nettype wire
